// ===== sv/wfba_pkg.sv =====
// ---------------------------------------------------------------------------
// wfba_pkg
// shared types and codes for the worst-fit block allocator
// ---------------------------------------------------------------------------
package wfba_pkg;

    localparam int unsigned COUNT_BITS = 5;
    localparam int unsigned SLOT_BITS  = 4;
    localparam int unsigned FIELD_BITS = 16;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_ALLOC = 1'b1;

    localparam logic [COUNT_BITS-1:0] BLOCK_COUNT_RESET = 5'd16;

    typedef struct packed {
        logic                  kind;
        logic [SLOT_BITS-1:0]  block_slot;
        logic [FIELD_BITS-1:0] size_value;
        logic                  request_last;
    } req_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] request_number;
        logic                  granted;
        logic [SLOT_BITS-1:0]  chosen_block;
        logic [FIELD_BITS-1:0] remaining_size;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic clear;
        logic sample;
    } cmp_ctl_t;

endpackage

// ===== sv/wfba_mem.sv =====
// ---------------------------------------------------------------------------
// wfba_mem
// free-size table, one write port and one registered read port
// ---------------------------------------------------------------------------
module wfba_mem #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned WIDTH = 16,
    parameter int unsigned AW    = 4
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/wfba_cmp.sv =====
// ---------------------------------------------------------------------------
// wfba_cmp
// shared compare unit, keeps the largest fitting block seen so far
// ---------------------------------------------------------------------------
module wfba_cmp #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned AW    = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  wfba_pkg::cmp_ctl_t  ctl,
    input  logic [WIDTH-1:0]    cand_size,
    input  logic [AW-1:0]       cand_idx,
    input  logic [WIDTH-1:0]    need_size,
    output logic                found,
    output logic [AW-1:0]       best_idx,
    output logic [WIDTH-1:0]    remain
);

    import wfba_pkg::*;

    logic             found_reg;
    logic             found_next;
    logic [AW-1:0]    best_idx_reg;
    logic [WIDTH-1:0] best_size_reg;
    logic             fits;
    logic             better;
    logic             take;

    assign fits       = cand_size >= need_size;
    assign better     = !found_reg || (cand_size > best_size_reg);
    assign take       = ctl.sample && fits && better;
    assign found_next = ctl.clear ? 1'b0 : (found_reg || take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!ctl.clear && take)
        begin
            best_idx_reg  <= cand_idx;
            best_size_reg <= cand_size;
        end
    end

    assign found    = found_reg;
    assign best_idx = best_idx_reg;
    assign remain   = best_size_reg - need_size;

endmodule

// ===== sv/wfba_ctrl.sv =====
// ---------------------------------------------------------------------------
// wfba_ctrl
// scan sequencer: walks the block table one entry per cycle
// ---------------------------------------------------------------------------
module wfba_ctrl #(
    parameter int unsigned AW = 4,
    parameter int unsigned CW = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [CW-1:0]       used,
    input  logic                out_free,
    output logic                req_ready,
    output logic                rd_en,
    output logic [AW-1:0]       rd_addr,
    output wfba_pkg::cmp_ctl_t  ctl,
    output logic [AW-1:0]       samp_idx,
    output logic                fire
);

    import wfba_pkg::*;

    state_t        state_reg;
    state_t        state_next;
    logic [CW-1:0] addr_reg;
    logic [CW-1:0] addr_next;
    logic          samp_vld_reg;
    logic [AW-1:0] samp_idx_reg;
    logic [CW-1:0] addr_inc;
    logic          last_issue;

    assign addr_inc   = addr_reg + CW'(1);
    assign last_issue = addr_inc == used;

    // next state
    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                addr_next = '0;
                if (start)
                begin
                    state_next = (used == '0) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                addr_next = addr_inc;
                if (last_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        req_ready  = 1'b0;
        rd_en      = 1'b0;
        fire       = 1'b0;
        unique case (state_reg)
            ST_IDLE:   req_ready = 1'b1;
            ST_SCAN:   rd_en     = 1'b1;
            ST_DRAIN:  rd_en     = 1'b0;
            ST_FINISH: fire      = out_free;
            default:   req_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            addr_reg     <= '0;
            samp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            samp_vld_reg <= rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        samp_idx_reg <= addr_reg[AW-1:0];
    end

    assign rd_addr    = addr_reg[AW-1:0];
    assign ctl.clear  = start;
    assign ctl.sample = samp_vld_reg;
    assign samp_idx   = samp_idx_reg;

endmodule

// ===== sv/worst_fit_block_allocator_unit.sv =====
// load request: written to the table when taken, no response
// allocate request: reads and compares the n blocks in use, response registered once the output is free
// no request is taken while an allocate scans, one table read per block, or waits for a free output
// a request is taken while an earlier response still waits
// reset (rst_n low, asynchronous): block_count 16, numbering 0, sizes unset
// ---------------------------------------------------------------------------
// worst_fit_block_allocator_unit
// worst-fit allocator over a table of block free sizes
// ---------------------------------------------------------------------------
module worst_fit_block_allocator_unit #(
    parameter int unsigned MAX_BLOCKS = 16,
    parameter int unsigned SIZE_BITS  = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  req_valid,
    output logic                                  req_ready,
    input  wfba_pkg::req_t                        req_data,
    output logic                                  rsp_valid,
    input  logic                                  rsp_ready,
    output wfba_pkg::rsp_t                        rsp_data,
    input  logic                                  cfg_we,
    input  logic [wfba_pkg::COUNT_BITS-1:0]       cfg_data
);

    import wfba_pkg::*;

    localparam int unsigned AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);

    logic [COUNT_BITS-1:0] block_count_reg;
    logic [FIELD_BITS-1:0] counter_reg;
    logic [FIELD_BITS-1:0] counter_next;
    logic [SIZE_BITS-1:0]  need_reg;
    logic                  last_reg;
    rsp_t                  out_reg;
    rsp_t                  out_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    logic [31:0]           used32;
    logic [CW-1:0]         used;
    logic [31:0]           slot32;
    logic [31:0]           size32;
    logic [SIZE_BITS-1:0]  size_in;
    logic                  accept;
    logic                  start;
    logic                  load_wr;
    logic                  out_free;

    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [SIZE_BITS-1:0]  rd_data;
    cmp_ctl_t              ctl;
    logic [AW-1:0]         samp_idx;
    logic                  fire;
    logic                  found;
    logic [AW-1:0]         best_idx;
    logic [SIZE_BITS-1:0]  remain;
    logic [31:0]           best32;
    logic [31:0]           remain32;

    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [SIZE_BITS-1:0]  wr_data;

    assign used32  = (32'(block_count_reg) > MAX_BLOCKS) ? MAX_BLOCKS
                                                         : 32'(block_count_reg);
    assign used    = used32[CW-1:0];
    assign slot32  = 32'(req_data.block_slot);
    assign size32  = 32'(req_data.size_value);
    assign size_in = size32[SIZE_BITS-1:0];

    assign accept   = req_valid && req_ready;
    assign start    = accept && (req_data.kind == KIND_ALLOC);
    assign load_wr  = accept && (req_data.kind == KIND_LOAD) && (slot32 < MAX_BLOCKS);
    assign out_free = !out_valid_reg || rsp_ready;

    wfba_ctrl #(
        .AW (AW),
        .CW (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .used      (used),
        .out_free  (out_free),
        .req_ready (req_ready),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .ctl       (ctl),
        .samp_idx  (samp_idx),
        .fire      (fire)
    );

    wfba_mem #(
        .DEPTH (MAX_BLOCKS),
        .WIDTH (SIZE_BITS),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    wfba_cmp #(
        .WIDTH (SIZE_BITS),
        .AW    (AW)
    ) u_cmp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .cand_size (rd_data),
        .cand_idx  (samp_idx),
        .need_size (need_reg),
        .found     (found),
        .best_idx  (best_idx),
        .remain    (remain)
    );

    // table write: loads when idle, the chosen block at the end of a scan
    assign wr_en   = load_wr || (fire && found);
    assign wr_addr = fire ? best_idx : slot32[AW-1:0];
    assign wr_data = fire ? remain : size_in;

    assign best32   = 32'(best_idx);
    assign remain32 = 32'(remain);

    always_comb
    begin
        out_next                = out_reg;
        out_valid_next          = out_valid_reg;
        counter_next            = counter_reg;
        if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (fire)
        begin
            out_valid_next          = 1'b1;
            out_next.request_number = counter_reg;
            out_next.granted        = found;
            out_next.chosen_block   = found ? best32[SLOT_BITS-1:0] : '0;
            out_next.remaining_size = found ? remain32[FIELD_BITS-1:0] : '0;
            counter_next            = last_reg ? '0 : counter_reg + FIELD_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg <= BLOCK_COUNT_RESET;
            counter_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                block_count_reg <= cfg_data;
            end
            counter_reg   <= counter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            need_reg <= size_in;
            last_reg <= req_data.request_last;
        end
        out_reg <= out_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

endmodule

// ===== sv/wfba_checker.sv =====
// ---------------------------------------------------------------------------
// wfba_checker
// port-level checks for the worst-fit block allocator
// ---------------------------------------------------------------------------
module wfba_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            req_valid,
    input logic                            req_ready,
    input wfba_pkg::req_t                  req_data,
    input logic                            rsp_valid,
    input logic                            rsp_ready,
    input wfba_pkg::rsp_t                  rsp_data
);

    import wfba_pkg::*;

    // response holds until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped before it was taken");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_data))
        else $error("response payload changed while stalled");

    // an allocate request keeps the block busy for the scan
    a_alloc_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_data.kind == KIND_ALLOC) |=> !req_ready)
        else $error("new request taken during a scan");

    // a load request never produces a response
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_data.kind == KIND_LOAD) && !rsp_valid
        |=> !rsp_valid)
        else $error("response appeared after a load request");

    // a new response only appears at the end of a scan
    a_rsp_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(!req_ready))
        else $error("response appeared while idle");

endmodule

bind worst_fit_block_allocator_unit wfba_checker u_wfba_checker (.*);

// ===== test/tb_worst_fit_block_allocator_unit.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_worst_fit_block_allocator_unit
// loads block sizes and sends allocate requests under random bursts and
// response stalls, a local worst-fit table predicts each response, checked
// field by field across several block counts
// ---------------------------------------------------------------------------
module tb_worst_fit_block_allocator_unit;

    import wfba_pkg::*;

    localparam int unsigned BLOCKS       = 16;
    localparam int unsigned DRAIN_CYCLES = 24;
    localparam int unsigned PHASES       = 10;
    localparam int unsigned PHASE_ITEMS  = 195;
    localparam int unsigned MAX_PRINTS   = 100;
    localparam longint     TIMEOUT_NS    = 64'd10_000_000;

    typedef enum int {
        RECV_ALWAYS,
        RECV_RANDOM,
        RECV_PERIODIC
    } recv_mode_e;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    req_t                  req_data = '0;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    rsp_t                  rsp_data;
    logic                  cfg_we = 1'b0;
    logic [COUNT_BITS-1:0] cfg_data = '0;

    req_t        request_queue[$];
    rsp_t        grant_queue[$];
    logic        req_fire = 1'b0;
    int unsigned error_count = 0;

    // worst-fit table kept by the testbench
    logic [FIELD_BITS-1:0] free_size[BLOCKS];
    logic [FIELD_BITS-1:0] batch_index = '0;
    logic [COUNT_BITS-1:0] blocks_in_use = BLOCK_COUNT_RESET;

    // sender bursts and receiver stalls
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    int unsigned gap_max = 0;
    recv_mode_e  recv_mode = RECV_ALWAYS;
    int unsigned stall_period = 5;
    int unsigned stall_low = 2;
    int unsigned recv_cycle = 0;

    worst_fit_block_allocator_unit #(
        .MAX_BLOCKS (BLOCKS),
        .SIZE_BITS  (FIELD_BITS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_PRINTS)
        begin
            $display("ERROR %0t ns: %s", $time, msg);
        end
        error_count++;
    endtask

    task automatic allocate_worst_fit(input req_t r);
        int unsigned scan_len;
        int          best;
        rsp_t        res;
        best = -1;
        res = '0;
        if (r.kind == KIND_LOAD)
        begin
            free_size[r.block_slot] = r.size_value;
        end
        else
        begin
            scan_len = (blocks_in_use > BLOCKS) ? BLOCKS : blocks_in_use;
            for (int j = 0; j < scan_len; j++)
            begin
                if (free_size[j] >= r.size_value &&
                    (best < 0 || free_size[j] > free_size[best]))
                begin
                    best = j;
                end
            end
            res.request_number = batch_index;
            if (best >= 0)
            begin
                free_size[best]     = free_size[best] - r.size_value;
                res.granted         = 1'b1;
                res.chosen_block    = best[SLOT_BITS-1:0];
                res.remaining_size  = free_size[best];
            end
            batch_index = r.request_last ? '0 : batch_index + 1'b1;
            grant_queue.push_back(res);
        end
    endtask

    // driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else if (!req_valid || req_fire)
        begin
            if (gap_left != 0)
            begin
                gap_left--;
                req_valid <= 1'b0;
            end
            else if (request_queue.size() != 0)
            begin
                req_data  <= request_queue.pop_front();
                req_valid <= 1'b1;
                if (burst_left != 0)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
                end
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // receiver stalls
    always @(negedge clk)
    begin
        recv_cycle++;
        case (recv_mode)
            RECV_ALWAYS:   rsp_ready <= 1'b1;
            RECV_RANDOM:   rsp_ready <= ($urandom_range(0, 99) < 60);
            default:       rsp_ready <= ((recv_cycle % stall_period) >= stall_low);
        endcase
    end

    // monitor
    always @(posedge clk)
    begin
        rsp_t want;
        req_fire <= req_valid && req_ready;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                blocks_in_use = cfg_data;
            end
            if (rsp_valid && rsp_ready)
            begin
                if (grant_queue.size() == 0)
                begin
                    report_mismatch($sformatf("response with none expected: %p", rsp_data));
                end
                else
                begin
                    want = grant_queue.pop_front();
                    if (rsp_data.request_number !== want.request_number)
                        report_mismatch($sformatf("request_number got %0d want %0d",
                            rsp_data.request_number, want.request_number));
                    if (rsp_data.granted !== want.granted)
                        report_mismatch($sformatf("granted got %0b want %0b",
                            rsp_data.granted, want.granted));
                    if (rsp_data.chosen_block !== want.chosen_block)
                        report_mismatch($sformatf("chosen_block got %0d want %0d",
                            rsp_data.chosen_block, want.chosen_block));
                    if (rsp_data.remaining_size !== want.remaining_size)
                        report_mismatch($sformatf("remaining_size got %0d want %0d",
                            rsp_data.remaining_size, want.remaining_size));
                end
            end
            if (req_valid && req_ready)
            begin
                allocate_worst_fit(req_data);
            end
        end
    end

    function automatic req_t make_request(input logic kind, input int unsigned slot,
                                          input int unsigned size, input logic last);
        req_t r;
        r.kind         = kind;
        r.block_slot   = slot[SLOT_BITS-1:0];
        r.size_value   = size[FIELD_BITS-1:0];
        r.request_last = last;
        return r;
    endfunction

    task automatic queue_random_requests(input int unsigned count);
        logic        kind;
        int unsigned size;
        repeat (count)
        begin
            kind = ($urandom_range(0, 99) < 30) ? KIND_LOAD : KIND_ALLOC;
            case ($urandom_range(0, 5))
                0:       size = $urandom_range(0, 1) ? 32'hFFFF : 0;
                1:       size = $urandom_range(0, 65535);
                2:       size = $urandom_range(0, 255);
                default: size = (kind == KIND_LOAD) ? $urandom_range(0, 20000)
                                                    : $urandom_range(0, 3000);
            endcase
            request_queue.push_back(make_request(kind, $urandom_range(0, BLOCKS - 1),
                                                 size, $urandom_range(0, 7) == 0));
        end
    endtask

    // sample after the driver's updates at this edge have settled
    task automatic wait_until_idle();
        do
        begin
            @(negedge clk);
            #1;
        end
        while (request_queue.size() != 0 || req_valid || grant_queue.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_block_count(input int unsigned value);
        cfg_data <= value[COUNT_BITS-1:0];
        cfg_we   <= 1'b1;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    initial
    begin
        int unsigned load_sizes[BLOCKS];
        int unsigned fixed_counts[7];
        int unsigned count;
        load_sizes   = '{100, 65535, 65535, 0, 1, 2, 500, 1000,
                         40000, 32768, 7, 21845, 43690, 10, 11, 12};
        fixed_counts = '{16, 0, 31, 1, 17, 15, 2};
        for (int i = 0; i < BLOCKS; i++)
        begin
            free_size[i] = '0;
        end
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // fill every block before any allocate, ties and both extremes included
        for (int i = 0; i < BLOCKS; i++)
        begin
            request_queue.push_back(make_request(KIND_LOAD, i, load_sizes[i], i == 3));
        end
        request_queue.push_back(make_request(KIND_ALLOC, 15, 65535, 1'b0));
        request_queue.push_back(make_request(KIND_ALLOC, 0, 0, 1'b0));
        request_queue.push_back(make_request(KIND_ALLOC, 0, 65535, 1'b0));
        request_queue.push_back(make_request(KIND_ALLOC, 0, 65535, 1'b0));
        request_queue.push_back(make_request(KIND_ALLOC, 0, 40001, 1'b0));
        request_queue.push_back(make_request(KIND_ALLOC, 0, 1, 1'b1));
        request_queue.push_back(make_request(KIND_ALLOC, 0, 0, 1'b0));

        for (int p = 0; p < PHASES; p++)
        begin
            wait_until_idle();
            count        = (p < 7) ? fixed_counts[p] : $urandom_range(0, 31);
            gap_max      = (p % 3 == 0) ? 0 : $urandom_range(2, 10);
            recv_mode    = recv_mode_e'(p % 3);
            stall_period = $urandom_range(4, 12);
            stall_low    = $urandom_range(1, stall_period - 1);
            write_block_count(count);
            queue_random_requests(PHASE_ITEMS);
        end

        wait_until_idle();
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
